@@ hw/rtl/bsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants for the bounded sorted pair list.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int TILE_BITS_DEF = 12;
  localparam int KEY_BITS_DEF  = 32;
  localparam int REQ_W         = 2;
  localparam int COUNT_W       = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_POP    = 2'd2,
    REQ_RESET  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_ADD,
    CMD_POP,
    CMD_CLEAR,
    CMD_MARK,
    CMD_COMPACT
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_COMPACT
  } state_e;

  typedef struct packed {
    cmd_e cmd;
    logic phase;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/bsp_cell.sv @@
// ----------------------------------------------------------------------------
// bsp_cell
// One slot of the sorted list: compare-and-shift for add, shift for pop,
// match-and-drop for remove, pairwise gap closing for compaction, and clear for reset.
// ----------------------------------------------------------------------------
module bsp_cell #(
  parameter int TILE_BITS = bsp_pkg::TILE_BITS_DEF,
  parameter int KEY_BITS  = bsp_pkg::KEY_BITS_DEF,
  parameter bit PARITY    = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bsp_pkg::cell_ctrl_t    ctrl_i,
  input  logic [TILE_BITS-1:0]   new_first_i,
  input  logic [TILE_BITS-1:0]   new_second_i,
  input  logic [KEY_BITS-1:0]    new_key_i,
  input  logic                   left_valid_i,
  input  logic                   left_ins_i,
  input  logic [TILE_BITS-1:0]   left_first_i,
  input  logic [TILE_BITS-1:0]   left_second_i,
  input  logic [KEY_BITS-1:0]    left_key_i,
  input  logic                   right_valid_i,
  input  logic [TILE_BITS-1:0]   right_first_i,
  input  logic [TILE_BITS-1:0]   right_second_i,
  input  logic [KEY_BITS-1:0]    right_key_i,
  output logic                   valid_o,
  output logic                   ins_o,
  output logic [TILE_BITS-1:0]   first_o,
  output logic [TILE_BITS-1:0]   second_o,
  output logic [KEY_BITS-1:0]    key_o
);

  logic                 valid_q, valid_d;
  logic [TILE_BITS-1:0] first_q, first_d;
  logic [TILE_BITS-1:0] second_q, second_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic                 ins;
  logic                 hit;

  assign ins = !valid_q || (new_key_i < key_q);
  assign hit = (first_q == new_first_i) || (second_q == new_first_i) ||
               (first_q == new_second_i) || (second_q == new_second_i);

  always_comb begin
    valid_d  = valid_q;
    first_d  = first_q;
    second_d = second_q;
    key_d    = key_q;
    unique case (ctrl_i.cmd)
      bsp_pkg::CMD_ADD: begin
        if (ins) begin
          if (left_ins_i) begin
            valid_d  = left_valid_i;
            first_d  = left_first_i;
            second_d = left_second_i;
            key_d    = left_key_i;
          end else begin
            valid_d  = 1'b1;
            first_d  = new_first_i;
            second_d = new_second_i;
            key_d    = new_key_i;
          end
        end
      end
      bsp_pkg::CMD_POP: begin
        valid_d  = right_valid_i;
        first_d  = right_first_i;
        second_d = right_second_i;
        key_d    = right_key_i;
      end
      bsp_pkg::CMD_CLEAR: valid_d = 1'b0;
      bsp_pkg::CMD_MARK: begin
        if (valid_q && hit) valid_d = 1'b0;
      end
      bsp_pkg::CMD_COMPACT: begin
        if (ctrl_i.phase == PARITY) begin
          if (!valid_q && right_valid_i) begin
            valid_d  = 1'b1;
            first_d  = right_first_i;
            second_d = right_second_i;
            key_d    = right_key_i;
          end
        end else if (valid_q && !left_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    key_q    <= key_d;
  end

  assign valid_o  = valid_q;
  assign ins_o    = ins;
  assign first_o  = first_q;
  assign second_o = second_q;
  assign key_o    = key_q;

endmodule

@@ hw/rtl/bounded_sorted_pair_list.sv @@
// ----------------------------------------------------------------------------
// bounded_sorted_pair_list
// Ascending list of tile pairs keyed by cost, built as a row of cells.
// ----------------------------------------------------------------------------
//   channel | signals                              | direction
//   in      | in_valid_i / in_stall_o, request     | into block
//   out     | out_valid_o / out_stall_i, result    | out of block
//
// Add, pop and reset: the result is registered at the accepting edge.
// Remove: a marking step, then compaction steps that alternate the odd/even
// gap-closing phases until no gap is left, then the result is posted once the
// output is free.
// Reset empties the list at once; no clearing pass.
// Requests are stalled during compaction and while a result is stalled.
// ----------------------------------------------------------------------------
module bounded_sorted_pair_list #(
  parameter int CAPACITY  = bsp_pkg::CAPACITY_DEF,
  parameter int TILE_BITS = bsp_pkg::TILE_BITS_DEF,
  parameter int KEY_BITS  = bsp_pkg::KEY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bsp_pkg::REQ_W-1:0]    req_type_i,
  input  logic [TILE_BITS-1:0]         first_tile_i,
  input  logic [TILE_BITS-1:0]         second_tile_i,
  input  logic [KEY_BITS-1:0]          cost_key_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         pop_valid_o,
  output logic [TILE_BITS-1:0]         popped_first_o,
  output logic [TILE_BITS-1:0]         popped_second_o,
  output logic [KEY_BITS-1:0]          popped_key_o,
  output logic [bsp_pkg::COUNT_W-1:0]  entry_count_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0]  valid;
  logic [CAPACITY-1:0]  ins;
  logic [TILE_BITS-1:0] first  [CAPACITY];
  logic [TILE_BITS-1:0] second [CAPACITY];
  logic [KEY_BITS-1:0]  key    [CAPACITY];

  bsp_pkg::cell_ctrl_t  cell_ctrl;
  bsp_pkg::state_e      state_q, state_d;
  bsp_pkg::req_e        req;
  logic                 phase_q, phase_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     therm_count;
  logic                 gap;
  logic                 in_accept;
  logic                 out_free;
  logic                 load_out;
  logic                 out_valid_q;
  logic                 pop_valid_q, pop_valid_d;
  logic [TILE_BITS-1:0] pf_q, pf_d;
  logic [TILE_BITS-1:0] ps_q, ps_d;
  logic [KEY_BITS-1:0]  pk_q, pk_d;
  logic [bsp_pkg::COUNT_W-1:0]       cnt_out_q;
  logic [CNT_W+bsp_pkg::COUNT_W-1:0] cnt_wide;

  assign req       = bsp_pkg::req_e'(req_type_i);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != bsp_pkg::ST_IDLE) || !out_free;
  assign in_accept = in_valid_i && !in_stall_o;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 lv, li, rv;
    logic [TILE_BITS-1:0] lf, ls, rf, rs;
    logic [KEY_BITS-1:0]  lk, rk;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign li = 1'b0;
      assign lf = first_tile_i;
      assign ls = second_tile_i;
      assign lk = cost_key_i;
    end else begin : g_body
      assign lv = valid[i-1];
      assign li = ins[i-1];
      assign lf = first[i-1];
      assign ls = second[i-1];
      assign lk = key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rv = 1'b0;
      assign rf = first_tile_i;
      assign rs = second_tile_i;
      assign rk = cost_key_i;
    end else begin : g_next
      assign rv = valid[i+1];
      assign rf = first[i+1];
      assign rs = second[i+1];
      assign rk = key[i+1];
    end

    bsp_cell #(
      .TILE_BITS (TILE_BITS),
      .KEY_BITS  (KEY_BITS),
      .PARITY    (1'(i % 2))
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (cell_ctrl),
      .new_first_i    (first_tile_i),
      .new_second_i   (second_tile_i),
      .new_key_i      (cost_key_i),
      .left_valid_i   (lv),
      .left_ins_i     (li),
      .left_first_i   (lf),
      .left_second_i  (ls),
      .left_key_i     (lk),
      .right_valid_i  (rv),
      .right_first_i  (rf),
      .right_second_i (rs),
      .right_key_i    (rk),
      .valid_o        (valid[i]),
      .ins_o          (ins[i]),
      .first_o        (first[i]),
      .second_o       (second[i]),
      .key_o          (key[i])
    );
  end

  always_comb begin
    gap         = 1'b0;
    therm_count = '0;
    for (int i = 0; i < CAPACITY - 1; i++) begin
      gap = gap | (!valid[i] && valid[i+1]);
      if (valid[i] && !valid[i+1]) therm_count = therm_count | CNT_W'(i + 1);
    end
    if (valid[CAPACITY-1]) therm_count = therm_count | CNT_W'(CAPACITY);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsp_pkg::ST_IDLE: begin
        if (in_accept && req == bsp_pkg::REQ_REMOVE) state_d = bsp_pkg::ST_COMPACT;
      end
      bsp_pkg::ST_COMPACT: begin
        if (!gap && out_free) state_d = bsp_pkg::ST_IDLE;
      end
      default: state_d = bsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cell_ctrl.cmd   = bsp_pkg::CMD_HOLD;
    cell_ctrl.phase = phase_q;
    phase_d         = phase_q;
    load_out        = 1'b0;
    count_d         = count_q;
    unique case (state_q)
      bsp_pkg::ST_IDLE: begin
        phase_d = 1'b0;
        if (in_accept) begin
          unique case (req)
            bsp_pkg::REQ_ADD: begin
              cell_ctrl.cmd = bsp_pkg::CMD_ADD;
              load_out      = 1'b1;
              if (count_q != CNT_W'(CAPACITY)) count_d = count_q + CNT_W'(1);
            end
            bsp_pkg::REQ_REMOVE: cell_ctrl.cmd = bsp_pkg::CMD_MARK;
            bsp_pkg::REQ_POP: begin
              cell_ctrl.cmd = bsp_pkg::CMD_POP;
              load_out      = 1'b1;
              if (count_q != '0) count_d = count_q - CNT_W'(1);
            end
            bsp_pkg::REQ_RESET: begin
              cell_ctrl.cmd = bsp_pkg::CMD_CLEAR;
              load_out      = 1'b1;
              count_d       = '0;
            end
            default: ;
          endcase
        end
      end
      bsp_pkg::ST_COMPACT: begin
        if (gap) begin
          cell_ctrl.cmd = bsp_pkg::CMD_COMPACT;
          phase_d       = !phase_q;
        end else if (out_free) begin
          load_out = 1'b1;
          count_d  = therm_count;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    pop_valid_d = 1'b0;
    pf_d        = '0;
    ps_d        = '0;
    pk_d        = '0;
    if (state_q == bsp_pkg::ST_IDLE && req == bsp_pkg::REQ_POP && valid[0]) begin
      pop_valid_d = 1'b1;
      pf_d        = first[0];
      ps_d        = second[0];
      pk_d        = key[0];
    end
  end

  assign cnt_wide = {{bsp_pkg::COUNT_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsp_pkg::ST_IDLE;
      phase_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pop_valid_q <= pop_valid_d;
      pf_q        <= pf_d;
      ps_q        <= ps_d;
      pk_q        <= pk_d;
      cnt_out_q   <= cnt_wide[bsp_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pop_valid_o     = pop_valid_q;
  assign popped_first_o  = pf_q;
  assign popped_second_o = ps_q;
  assign popped_key_o    = pk_q;
  assign entry_count_o   = cnt_out_q;

endmodule

@@ hw/rtl/bsp_checker.sv @@
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks on the bounded sorted pair list.
// ----------------------------------------------------------------------------
module bsp_checker #(
  parameter int TILE_BITS = bsp_pkg::TILE_BITS_DEF,
  parameter int KEY_BITS  = bsp_pkg::KEY_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [bsp_pkg::REQ_W-1:0]    req_type_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         pop_valid_o,
  input logic [TILE_BITS-1:0]         popped_first_o,
  input logic [TILE_BITS-1:0]         popped_second_o,
  input logic [KEY_BITS-1:0]          popped_key_o,
  input logic [bsp_pkg::COUNT_W-1:0]  entry_count_o
);

  logic in_acc;
  logic add_or_reset;

  assign in_acc       = in_valid_i && !in_stall_o;
  assign add_or_reset = (req_type_i == bsp_pkg::REQ_ADD) ||
                        (req_type_i == bsp_pkg::REQ_RESET);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(popped_key_o) &&
      $stable(entry_count_o))
    else $error("stalled result changed");

  a_empty_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pop_valid_o |->
      popped_first_o == '0 && popped_second_o == '0 && popped_key_o == '0)
    else $error("result fields not zero without a popped entry");

  a_reset_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == bsp_pkg::REQ_RESET |=> out_valid_o && entry_count_o == '0)
    else $error("reset request did not empty the list");

  a_no_pop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && add_or_reset |=> out_valid_o && !pop_valid_o)
    else $error("pop flag on a request other than pop");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while result stalled");

endmodule

bind bounded_sorted_pair_list bsp_checker #(
  .TILE_BITS (TILE_BITS),
  .KEY_BITS  (KEY_BITS)
) u_bsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .req_type_i      (req_type_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .pop_valid_o     (pop_valid_o),
  .popped_first_o  (popped_first_o),
  .popped_second_o (popped_second_o),
  .popped_key_o    (popped_key_o),
  .entry_count_o   (entry_count_o)
);
